@@ design/fcls_pkg.sv @@
// Shared types, constants and helpers for the frame checksum block.
// Used by frame_checksum_with_link_signature; no dependencies.
package fcls_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SigW  = 16;
  localparam int unsigned CntW  = 2;
  localparam int unsigned OutW  = 24;  // 18 payload bits rounded up to whole bytes

  localparam logic [ByteW-1:0] AllOnes = {ByteW{1'b1}};
  localparam logic [CntW-1:0]  CntFull = CntW'(2);

  // Configuration register indexes
  localparam logic CFG_VERIFY_MODE = 1'b0;
  localparam logic CFG_LINK_SIG    = 1'b1;

  // Finalize job handed from the byte stage to the result stage
  typedef struct packed {
    logic             short_frame;
    logic             verify;
    logic [SigW-1:0]  sig;
    logic [ByteW-1:0] sum_low;
    logic [ByteW-1:0] sum_high;
    logic [ByteW-1:0] slot0;
    logic [ByteW-1:0] slot1;
  } job_t;

  // 8-bit add with end-around carry
  function automatic logic [ByteW-1:0] eac_add(input logic [ByteW-1:0] a,
                                              input logic [ByteW-1:0] b);
    logic [ByteW:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[ByteW-1:0] + {{(ByteW-1){1'b0}}, t[ByteW]};
  endfunction

endpackage

@@ design/frame_checksum_with_link_signature.sv @@
// Frame checksum with link signature: top level, byte stage and result stage.
// Depends on fcls_pkg.
// Throughput: one byte per cycle while s_axis_tready is high. The result of a frame
// goes to the byte stage register and then the result register after its last byte.
// Bytes are held off only when a finished job and the output register are both full.
// Reset clears the sums, the two-byte delay, the config registers and valid flags.
module frame_checksum_with_link_signature (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [fcls_pkg::SigW-1:0]     cfg_wdata_i,
  // byte stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fcls_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // is_last
  // result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] first_check, [15:8] second_check, [16] check_ok, [17] short_frame, rest 0
  output logic [fcls_pkg::OutW-1:0]     m_axis_tdata
);

  localparam int unsigned BW = fcls_pkg::ByteW;

  // config registers
  logic                     verify_q;
  logic [fcls_pkg::SigW-1:0] sig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verify_q <= 1'b0;
      sig_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcls_pkg::CFG_VERIFY_MODE: verify_q <= cfg_wdata_i[0];
        fcls_pkg::CFG_LINK_SIG:    sig_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic out_valid_q, job_valid_q;
  logic out_free, job_free, accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign job_free      = !job_valid_q || out_free;
  assign s_axis_tready = job_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // byte stage: running sums and two-byte slot delay
  logic [BW-1:0]             sum_low_q, sum_high_q, sum_low_d, sum_high_d;
  logic [BW-1:0]             held0_q, held1_q, held0_d, held1_d;
  logic [fcls_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [BW-1:0]             fold_low, fold_high;
  logic                      is_short, job_load;
  fcls_pkg::job_t            job_q, job_d;

  always_comb begin
    is_short  = s_axis_tlast && (cnt_q == '0);
    fold_low  = sum_low_q;
    fold_high = sum_high_q;
    if (cnt_q == fcls_pkg::CntFull) begin
      fold_low  = fcls_pkg::eac_add(sum_low_q, held0_q);
      fold_high = fcls_pkg::eac_add(sum_high_q, fold_low);
    end

    job_load          = s_axis_tlast;
    job_d.short_frame = is_short;
    job_d.verify      = verify_q;
    job_d.sig         = sig_q;
    job_d.sum_low     = fold_low;
    job_d.sum_high    = fold_high;
    job_d.slot0       = held1_q;
    job_d.slot1       = s_axis_tdata;

    if (s_axis_tlast) begin
      // frame ends: start the next one clean
      sum_low_d  = '0;
      sum_high_d = '0;
      held0_d    = '0;
      held1_d    = '0;
      cnt_d      = '0;
    end else begin
      sum_low_d  = fold_low;
      sum_high_d = fold_high;
      held0_d    = held1_q;
      held1_d    = s_axis_tdata;
      cnt_d      = (cnt_q == fcls_pkg::CntFull) ? cnt_q : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q  <= '0;
      sum_high_q <= '0;
      held0_q    <= '0;
      held1_q    <= '0;
      cnt_q      <= '0;
    end else if (accept) begin
      sum_low_q  <= sum_low_d;
      sum_high_q <= sum_high_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (job_free) begin
      job_valid_q <= accept && job_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && job_load) begin
      job_q <= job_d;
    end
  end

  // result stage: fold the slots and form the check bytes
  logic [BW-1:0] slot_a, slot_b, l1, h1, l2, h2;
  logic [BW-1:0] g_h1, g_h2, x_b, y_b, nl;
  logic [BW-1:0] first_d, second_d, first_q, second_q;
  logic          ok_d, short_d, ok_q, short_q;

  always_comb begin
    slot_a = job_q.slot0 ^ job_q.sig[2*BW-1:BW];
    slot_b = job_q.slot1 ^ job_q.sig[BW-1:0];
    l1 = fcls_pkg::eac_add(job_q.sum_low, slot_a);
    h1 = fcls_pkg::eac_add(job_q.sum_high, l1);
    l2 = fcls_pkg::eac_add(l1, slot_b);
    h2 = fcls_pkg::eac_add(h1, l2);

    // generate: slots count as zero, so sum_low stays and sum_high gains it twice
    g_h1 = fcls_pkg::eac_add(job_q.sum_high, job_q.sum_low);
    g_h2 = fcls_pkg::eac_add(g_h1, job_q.sum_low);
    nl   = ~job_q.sum_low;
    x_b  = fcls_pkg::eac_add(job_q.sum_low, ~g_h2);
    y_b  = fcls_pkg::eac_add(fcls_pkg::eac_add(nl, nl), g_h2);

    if (job_q.short_frame) begin
      first_d  = '0;
      second_d = '0;
      ok_d     = 1'b0;
      short_d  = 1'b1;
    end else if (job_q.verify) begin
      first_d  = l2;
      second_d = h2;
      ok_d     = (l2 == fcls_pkg::AllOnes) && (h2 == fcls_pkg::AllOnes);
      short_d  = 1'b0;
    end else begin
      first_d  = x_b ^ job_q.sig[2*BW-1:BW];
      second_d = y_b ^ job_q.sig[BW-1:0];
      ok_d     = 1'b0;
      short_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= job_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && job_valid_q) begin
      first_q  <= first_d;
      second_q <= second_d;
      ok_q     <= ok_d;
      short_q  <= short_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(fcls_pkg::OutW - 2*BW - 2)'(0), short_q, ok_q, second_q, first_q};

  // checks
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && short_q) |-> (first_q == '0 && second_q == '0 && !ok_q))
    else $error("short frame result carries nonzero check fields");

  a_ok_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ok_q) |-> (first_q == fcls_pkg::AllOnes && second_q == fcls_pkg::AllOnes))
    else $error("check_ok set without both sums at all ones");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("held byte count beyond two");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (cnt_q == '0 && sum_low_q == '0 && sum_high_q == '0))
    else $error("frame state not cleared after last beat");

  a_job_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && out_free) |=> out_valid_q)
    else $error("finished job lost on its way to the output register");

endmodule
